>>> hdl/sclru_pkg.sv
// sclru_pkg: constants, types and codes shared by the sector cache lookup block
// no dependencies
package sclru_pkg;

  // table geometry
  localparam int unsigned Slots       = 32;
  localparam int unsigned SlotW       = $clog2(Slots);
  localparam int unsigned SlotCntW    = $clog2(Slots + 1);

  // field widths
  localparam int unsigned AddrW       = 32;
  localparam int unsigned LenW        = 18;
  localparam int unsigned OffW        = 20;
  localparam int unsigned ClenW       = 21;
  localparam int unsigned StampW      = 32;
  localparam int unsigned LgW         = 5;

  // request limits
  localparam int unsigned MaxReadLength = 262143;
  localparam int unsigned MaxResults    = 33;
  localparam int unsigned ResCntW       = $clog2(MaxResults + 1);

  // block size limits (log2 of bytes)
  localparam int unsigned LgMin       = 13;
  localparam int unsigned LgMax       = 20;
  localparam int unsigned LgReset     = 14;

  // configuration port
  localparam int unsigned CfgIdxW     = 1;
  localparam int unsigned CfgDataW    = 6;
  localparam logic [CfgIdxW-1:0] CFG_BLOCK_SIZE_LOG2 = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_SLOTS_IN_USE    = 1'b1;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_SCAN,
    ST_WRITE
  } seq_state_e;

  // slot table write port
  typedef struct packed {
    logic              en;
    logic [SlotW-1:0]  idx;
    logic [AddrW-1:0]  tag;
    logic [StampW-1:0] stamp;
  } slot_wr_t;

  // slot table read data, empty slots read as zero
  typedef struct packed {
    logic [AddrW-1:0]  tag;
    logic [StampW-1:0] stamp;
  } slot_rd_t;

  // one result item
  typedef struct packed {
    logic [SlotW-1:0] slot_index;
    logic             hit;
    logic [AddrW-1:0] block_address;
    logic [OffW-1:0]  offset_in_block;
    logic [ClenW-1:0] chunk_length;
    logic             last_chunk;
  } rsp_t;

endpackage

>>> hdl/sclru_if.sv
// sclru_if: valid/ready channel interfaces for request and result items
// depends on sclru_pkg
interface sclru_req_if;
  logic                         valid;
  logic                         ready;
  logic [sclru_pkg::AddrW-1:0]  read_address;
  logic [sclru_pkg::LenW-1:0]   read_length;

  modport source(output valid, read_address, read_length, input ready);
  modport sink(input valid, read_address, read_length, output ready);
endinterface

interface sclru_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [sclru_pkg::SlotW-1:0]  slot_index;
  logic                         hit;
  logic [sclru_pkg::AddrW-1:0]  block_address;
  logic [sclru_pkg::OffW-1:0]   offset_in_block;
  logic [sclru_pkg::ClenW-1:0]  chunk_length;
  logic                         last_chunk;

  modport source(output valid, slot_index, hit, block_address, offset_in_block,
                 chunk_length, last_chunk, input ready);
  modport sink(input valid, slot_index, hit, block_address, offset_in_block,
               chunk_length, last_chunk, output ready);
endinterface

>>> hdl/sclru_slot_store.sv
// sclru_slot_store: tag and stamp table with per-slot valid bits
// depends on sclru_pkg
module sclru_slot_store (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [sclru_pkg::SlotW-1:0] rd_idx_i,
  output sclru_pkg::slot_rd_t         rd_o,
  input  sclru_pkg::slot_wr_t         wr_i
);
  import sclru_pkg::*;

  logic [Slots-1:0]  valid_q;
  logic [AddrW-1:0]  tag_q   [Slots];
  logic [StampW-1:0] stamp_q [Slots];

  // valid bits, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_i.en) begin
      valid_q[wr_i.idx] <= 1'b1;
    end
  end

  // tag and stamp storage
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      tag_q[wr_i.idx]   <= wr_i.tag;
      stamp_q[wr_i.idx] <= wr_i.stamp;
    end
  end

  // read port, a never-written slot reads as zero
  always_comb begin
    if (valid_q[rd_idx_i]) begin
      rd_o.tag   = tag_q[rd_idx_i];
      rd_o.stamp = stamp_q[rd_idx_i];
    end else begin
      rd_o.tag   = '0;
      rd_o.stamp = '0;
    end
  end

endmodule

>>> hdl/sclru_seq.sv
// sclru_seq: chunk splitter and slot scan sequencer with one shared compare unit
// depends on sclru_pkg
module sclru_seq (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // request item
  input  logic                           req_valid_i,
  output logic                           req_ready_o,
  input  logic [sclru_pkg::AddrW-1:0]    req_addr_i,
  input  logic [sclru_pkg::LenW-1:0]     req_len_i,
  // clamped configuration
  input  logic [sclru_pkg::LgW-1:0]      lg_i,
  input  logic [sclru_pkg::SlotCntW-1:0] nslots_i,
  // slot table
  output logic [sclru_pkg::SlotW-1:0]    rd_idx_o,
  input  sclru_pkg::slot_rd_t            rd_i,
  output sclru_pkg::slot_wr_t            wr_o,
  // result register
  input  logic                           rsp_free_i,
  output logic                           rsp_load_o,
  output sclru_pkg::rsp_t                rsp_o
);
  import sclru_pkg::*;

  seq_state_e state_q, state_d;

  logic [AddrW-1:0]    addr_q;
  logic [LenW-1:0]     len_q;
  logic [StampW-1:0]   count_q;
  logic [LgW-1:0]      lg_q;
  logic [SlotCntW-1:0] nslots_q;
  logic [ResCntW-1:0]  nres_q;
  logic [AddrW-1:0]    blk_q;
  logic [OffW-1:0]     off_q;
  logic [LenW-1:0]     clen_q;
  logic [SlotW-1:0]    idx_q;
  logic                found_q;
  logic [SlotW-1:0]    fslot_q;
  logic [SlotW-1:0]    vslot_q;
  logic [StampW-1:0]   low_q;
  logic                vstop_q;

  logic                accept;
  logic [LenW-1:0]     len_sat;
  logic [AddrW-1:0]    bmask;
  logic [OffW-1:0]     off_d;
  logic [AddrW-1:0]    rem_full;
  logic [ClenW-1:0]    rem;
  logic [LenW-1:0]     clen_d;
  logic                match;
  logic                take_victim;
  logic                scan_end;
  logic [LenW-1:0]     len_next;
  logic [ResCntW-1:0]  nres_next;
  logic                last;
  logic [SlotW-1:0]    slot_sel;
  logic                emit;

  assign accept  = (state_q == ST_IDLE) && req_valid_i;
  assign len_sat = (req_len_i > LenW'(MaxReadLength)) ? LenW'(MaxReadLength) : req_len_i;

  // chunk split arithmetic
  assign bmask    = (AddrW'(1) << lg_q) - AddrW'(1);
  assign off_d    = addr_q[OffW-1:0] & bmask[OffW-1:0];
  assign rem_full = (AddrW'(1) << lg_q) - {{(AddrW-OffW){1'b0}}, off_d};
  assign rem      = rem_full[ClenW-1:0];
  assign clen_d   = (rem > {{(ClenW-LenW){1'b0}}, len_q}) ? len_q : rem[LenW-1:0];

  // shared compare unit: tag match and stamp minimum for the slot under scan
  assign match       = (rd_i.stamp != '0) && (rd_i.tag == blk_q);
  assign take_victim = !vstop_q && (rd_i.stamp <= low_q);
  assign scan_end    = ({1'b0, idx_q} == (nslots_q - SlotCntW'(1)));

  // chunk retirement
  assign len_next  = len_q - clen_q;
  assign nres_next = nres_q + ResCntW'(1);
  assign last      = (len_next == '0) || (nres_next >= ResCntW'(MaxResults));
  assign slot_sel  = found_q ? fslot_q : vslot_q;
  assign emit      = (state_q == ST_WRITE) && rsp_free_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_valid_i && (len_sat != '0)) state_d = ST_SETUP;
      end
      ST_SETUP: begin
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (match || scan_end) state_d = ST_WRITE;
      end
      ST_WRITE: begin
        if (rsp_free_i) state_d = last ? ST_IDLE : ST_SETUP;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    req_ready_o = 1'b0;
    rsp_load_o  = 1'b0;
    wr_o        = '0;
    unique case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
      end
      ST_WRITE: begin
        if (rsp_free_i) begin
          rsp_load_o = 1'b1;
          wr_o.en    = 1'b1;
          wr_o.idx   = slot_sel;
          wr_o.tag   = blk_q;
          wr_o.stamp = count_q;
        end
      end
      default: ;
    endcase
  end

  assign rd_idx_o              = idx_q;
  assign rsp_o.slot_index      = slot_sel;
  assign rsp_o.hit             = found_q;
  assign rsp_o.block_address   = blk_q;
  assign rsp_o.offset_in_block = off_q;
  assign rsp_o.chunk_length    = {{(ClenW-LenW){1'b0}}, clen_q};
  assign rsp_o.last_chunk      = last;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      nres_q  <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        count_q <= count_q + StampW'(1);
        nres_q  <= '0;
      end else if (emit) begin
        nres_q <= nres_next;
        if (!last) count_q <= count_q + StampW'(1);
      end
    end
  end

  // request and chunk datapath
  always_ff @(posedge clk_i) begin
    if (accept) begin
      addr_q   <= req_addr_i;
      len_q    <= len_sat;
      lg_q     <= lg_i;
      nslots_q <= nslots_i;
    end
    if (state_q == ST_SETUP) begin
      blk_q   <= addr_q & ~bmask;
      off_q   <= off_d;
      clen_q  <= clen_d;
      idx_q   <= '0;
      found_q <= 1'b0;
      low_q   <= count_q;
      vslot_q <= '0;
      vstop_q <= 1'b0;
    end
    if (state_q == ST_SCAN) begin
      if (match) begin
        found_q <= 1'b1;
        fslot_q <= idx_q;
      end else begin
        if (take_victim) begin
          low_q   <= rd_i.stamp;
          vslot_q <= idx_q;
          if (rd_i.stamp == '0) vstop_q <= 1'b1;
        end
        if (!scan_end) idx_q <= idx_q + SlotW'(1);
      end
    end
    if (emit && !last) begin
      addr_q <= addr_q + {{(AddrW-LenW){1'b0}}, clen_q};
      len_q  <= len_next;
    end
  end

endmodule

>>> hdl/sector_cache_lookup_lru.sv
// per chunk: a setup state, a scan of slots 0 to slots_in_use-1 that stops at the first tag
// hit, then a write state that waits while the result register is still full
// one request at a time; the scan compares the slots in turn in the single slot compare
// unit; a zero-length request is accepted without producing a result
// reset: slot table empty, access counter zero, block_size_log2 = 14, slots_in_use = 32
// sector_cache_lookup_lru: top level, config registers, result register; needs sclru_*
module sector_cache_lookup_lru (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sclru_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [sclru_pkg::CfgDataW-1:0] cfg_wdata_i,
  sclru_req_if.sink                      req,
  sclru_rsp_if.source                    rsp
);
  import sclru_pkg::*;

  logic [LgW-1:0]      cfg_lg_q;
  logic [SlotCntW-1:0] cfg_slots_q;
  logic [LgW-1:0]      lg_eff;
  logic [SlotCntW-1:0] nslots_eff;

  logic                rsp_valid_q;
  rsp_t                rsp_q;
  logic                rsp_free;
  logic                rsp_load;
  rsp_t                rsp_d;

  logic [SlotW-1:0]    rd_idx;
  slot_rd_t            rd;
  slot_wr_t            wr;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_lg_q    <= LgW'(LgReset);
      cfg_slots_q <= SlotCntW'(Slots);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_BLOCK_SIZE_LOG2: cfg_lg_q    <= cfg_wdata_i[LgW-1:0];
        CFG_SLOTS_IN_USE:    cfg_slots_q <= cfg_wdata_i[SlotCntW-1:0];
        default: ;
      endcase
    end
  end

  // clamp configuration to its legal range
  assign lg_eff = (cfg_lg_q < LgW'(LgMin)) ? LgW'(LgMin) :
                  (cfg_lg_q > LgW'(LgMax)) ? LgW'(LgMax) : cfg_lg_q;
  assign nslots_eff = (cfg_slots_q == '0) ? SlotCntW'(1) :
                      (cfg_slots_q > SlotCntW'(Slots)) ? SlotCntW'(Slots) : cfg_slots_q;

  sclru_slot_store u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_idx_i (rd_idx),
    .rd_o     (rd),
    .wr_i     (wr)
  );

  sclru_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req.valid),
    .req_ready_o (req.ready),
    .req_addr_i  (req.read_address),
    .req_len_i   (req.read_length),
    .lg_i        (lg_eff),
    .nslots_i    (nslots_eff),
    .rd_idx_o    (rd_idx),
    .rd_i        (rd),
    .wr_o        (wr),
    .rsp_free_i  (rsp_free),
    .rsp_load_o  (rsp_load),
    .rsp_o       (rsp_d)
  );

  // result output register
  assign rsp_free = !rsp_valid_q || rsp.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (rsp_free) begin
      rsp_valid_q <= rsp_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_load) rsp_q <= rsp_d;
  end

  assign rsp.valid           = rsp_valid_q;
  assign rsp.slot_index      = rsp_q.slot_index;
  assign rsp.hit             = rsp_q.hit;
  assign rsp.block_address   = rsp_q.block_address;
  assign rsp.offset_in_block = rsp_q.offset_in_block;
  assign rsp.chunk_length    = rsp_q.chunk_length;
  assign rsp.last_chunk      = rsp_q.last_chunk;

endmodule
